// ===== hdl/gf256_arithmetic_unit_defines.svh =====
// Assertion macros shared by the GF(2^8) arithmetic unit.
`ifndef GF256_ARITHMETIC_UNIT_DEFINES_SVH
`define GF256_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GFAU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfau assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GFAU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfau assertion failed");
`else
`define GFAU_ASSERT_IMPL(label, ante, cons)
`define GFAU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hdl/gfau_pkg.sv =====
// Package: opcodes, pipeline control struct and GF(2^8) field functions.
`timescale 1ns / 1ps

package gfau_pkg;

    // Operation codes
    localparam logic [1:0] OP_MUL    = 2'd0;
    localparam logic [1:0] OP_SQR    = 2'd1;
    localparam logic [1:0] OP_INV    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Reduction feedback of x^8 + x^4 + x^3 + x^2 + 1
    localparam logic [7:0] FEEDBACK = 8'h1d;

    // Clock edges from the accepting edge to the edge that takes its result
    localparam int unsigned LATENCY = 8;

    // Control that travels with each item down the pipeline
    typedef struct packed {
        logic       valid;
        logic [1:0] opcode;
    } gfau_ctrl_t;

    // Multiply by x and reduce
    function automatic logic [7:0] gf_mul_x(input logic [7:0] v);
        gf_mul_x = {v[6:0], 1'b0} ^ (FEEDBACK & {8{v[7]}});
    endfunction

    // Shift-and-add multiply, top bit of b first
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 7; k >= 0; k--)
        begin
            acc = gf_mul_x(acc) ^ (a & {8{b[k]}});
        end
        gf_mul = acc;
    endfunction

    // Spread bits to even positions and fold back below degree 8
    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        logic [14:0] v;
        logic [6:0]  hi;
        v = 15'd0;
        for (int k = 0; k < 8; k++)
        begin
            v[2*k] = a[k];
        end
        for (int pass = 0; pass < 2; pass++)
        begin
            hi = v[14:8];
            v  = {7'd0, v[7:0]} ^ {8'd0, hi} ^ {6'd0, hi, 2'd0}
                ^ {5'd0, hi, 3'd0} ^ {4'd0, hi, 4'd0};
        end
        gf_sq = v[7:0];
    endfunction

endpackage

// ===== hdl/gfau_pipe.sv =====
// Seven-stage datapath: multiply and square results, and the a^127 power chain.
`timescale 1ns / 1ps

module gfau_pipe
    import gfau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] opcode,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    output gfau_ctrl_t ctrl_out,
    output logic [7:0] early_out,
    output logic [7:0] p127_out
);

    gfau_ctrl_t s1_ctrl_reg, s2_ctrl_reg, s3_ctrl_reg, s4_ctrl_reg;
    gfau_ctrl_t s5_ctrl_reg, s6_ctrl_reg, s7_ctrl_reg;
    gfau_ctrl_t s1_ctrl_next;

    logic [7:0] s1_early_reg, s2_early_reg, s3_early_reg, s4_early_reg;
    logic [7:0] s5_early_reg, s6_early_reg, s7_early_reg;
    logic [7:0] s1_early_next;

    logic [7:0] s1_a_reg, s1_p2_reg, s1_p4_reg;
    logic [7:0] s1_p2_next, s1_p4_next;
    logic [7:0] s2_p4_reg, s2_p3_reg, s2_p3_next;
    logic [7:0] s3_p4_reg, s3_p7_reg, s3_p7_next;
    logic [7:0] s4_p7_reg, s4_p4_reg, s4_p11_reg, s4_p11_next;
    logic [7:0] s5_p7_reg, s5_p15_reg, s5_p15_next;
    logic [7:0] s6_p7_reg, s6_p120_reg, s6_p120_next;
    logic [7:0] s7_p127_reg, s7_p127_next;

    // Stage 1: direct results and the first two powers of a
    always_comb
    begin
        s1_ctrl_next.valid  = in_valid;
        s1_ctrl_next.opcode = opcode;
        s1_p2_next          = gf_sq(operand_a);
        s1_p4_next          = gf_sq(s1_p2_next);
        case (opcode)
            OP_MUL:  s1_early_next = gf_mul(operand_a, operand_b);
            OP_SQR:  s1_early_next = s1_p2_next;
            default: s1_early_next = 8'h00;
        endcase
    end

    // Later stages: one field multiply or a short run of squares each
    always_comb
    begin
        s2_p3_next   = gf_mul(s1_p2_reg, s1_a_reg);
        s3_p7_next   = gf_mul(s2_p4_reg, s2_p3_reg);
        s4_p11_next  = gf_mul(s3_p4_reg, s3_p7_reg);
        s5_p15_next  = gf_mul(s4_p11_reg, s4_p4_reg);
        s6_p120_next = gf_sq(gf_sq(gf_sq(s5_p15_reg)));
        s7_p127_next = gf_mul(s6_p120_reg, s6_p7_reg);
    end

    // Advance control; reset drops every item in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_ctrl_reg <= '0;
            s4_ctrl_reg <= '0;
            s5_ctrl_reg <= '0;
            s6_ctrl_reg <= '0;
            s7_ctrl_reg <= '0;
        end
        else
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            s2_ctrl_reg <= s1_ctrl_reg;
            s3_ctrl_reg <= s2_ctrl_reg;
            s4_ctrl_reg <= s3_ctrl_reg;
            s5_ctrl_reg <= s4_ctrl_reg;
            s6_ctrl_reg <= s5_ctrl_reg;
            s7_ctrl_reg <= s6_ctrl_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        s1_a_reg     <= operand_a;
        s1_p2_reg    <= s1_p2_next;
        s1_p4_reg    <= s1_p4_next;
        s1_early_reg <= s1_early_next;

        s2_p4_reg    <= s1_p4_reg;
        s2_p3_reg    <= s2_p3_next;
        s2_early_reg <= s1_early_reg;

        s3_p4_reg    <= s2_p4_reg;
        s3_p7_reg    <= s3_p7_next;
        s3_early_reg <= s2_early_reg;

        s4_p4_reg    <= s3_p4_reg;
        s4_p7_reg    <= s3_p7_reg;
        s4_p11_reg   <= s4_p11_next;
        s4_early_reg <= s3_early_reg;

        s5_p7_reg    <= s4_p7_reg;
        s5_p15_reg   <= s5_p15_next;
        s5_early_reg <= s4_early_reg;

        s6_p7_reg    <= s5_p7_reg;
        s6_p120_reg  <= s6_p120_next;
        s6_early_reg <= s5_early_reg;

        s7_p127_reg  <= s7_p127_next;
        s7_early_reg <= s6_early_reg;
    end

    assign ctrl_out  = s7_ctrl_reg;
    assign early_out = s7_early_reg;
    assign p127_out  = s7_p127_reg;

endmodule

// ===== hdl/gf256_arithmetic_unit.sv =====
// Top level of the GF(2^8) arithmetic unit (multiply, square, inverse; poly 0x11D).
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------
//   command   start / busy         opcode, operand_a, operand_b
//   result    done (strobe)        result
//
// done and result are registered after pipeline stages s1 to s7, and one item
// can be accepted each cycle. The length is set by the inverse power chain:
// seven pipeline stages, most holding one field multiply, then the output
// register that applies the last square. busy stays low and the pipeline never
// stalls; the receiver must take every result, which the block does not
// enforce. Reset drops all items in flight.
`timescale 1ns / 1ps
`include "gf256_arithmetic_unit_defines.svh"

module gf256_arithmetic_unit
    import gfau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] opcode,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    output logic       done,
    output logic [7:0] result
);

    gfau_ctrl_t pipe_ctrl;
    logic [7:0] pipe_early;
    logic [7:0] pipe_p127;
    logic       done_reg;
    logic [7:0] result_reg;
    logic [7:0] result_next;

    // Never hold off the sender
    assign busy = 1'b0;

    gfau_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ctrl_out  (pipe_ctrl),
        .early_out (pipe_early),
        .p127_out  (pipe_p127)
    );

    // Last square of the inverse chain, then pick the result by opcode
    always_comb
    begin
        case (pipe_ctrl.opcode)
            OP_INV:  result_next = gf_sq(pipe_p127);
            default: result_next = pipe_early;
        endcase
    end

    // Hold the strobe for one cycle per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pipe_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Each strobe belongs to an item that start brought in while busy was low
    `GFAU_ASSERT_IMPL(a_done_has_item, done, $past(start && !busy, LATENCY))
    // Unused opcode yields zero
    `GFAU_ASSERT_IMPL(a_unused_op_zero, done && $past(opcode == OP_UNUSED, LATENCY), result == 8'h00)
    // Inverse of zero is zero
    `GFAU_ASSERT_IMPL(a_inv_zero, done && $past(opcode == OP_INV && operand_a == 8'h00, LATENCY), result == 8'h00)

endmodule
